FILE: hdl/aem_pkg.sv
// Shared types and constants for the minimum-extracting value store.
package aem_pkg;

    // Default number of entries in the store.
    localparam int AEM_DEPTH = 64;

    // Width of one stored word.
    localparam int AEM_DATA_W = 32;

    // Command codes carried by an input word.
    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_DUMP   = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    // Result kind codes.
    localparam logic KIND_DUMP = 1'b0;
    localparam logic KIND_MIN  = 1'b1;

endpackage

FILE: hdl/aem_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module aem_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds when no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/array_extract_minimum.sv
// Ordered store of signed words: append, dump in order, and remove the minimum.
//
// The block keeps up to DEPTH signed 32-bit words in one RAM with a registered
// read, plus an occupancy count. An append word produces no result; with
// start_new set it empties the store first, and once the store is full
// further appends are dropped. A dump produces one result per stored word, in
// order, with last set on the final one; each word is read, captured in the
// pending register and handed off to the output register, and the next read
// waits while a result is pending. A remove reads the stored words one per
// cycle to find the smallest (the earliest on ties), then moves each word
// behind it down one place at one word per cycle. Both walks are paced by the
// single RAM read port, which serves one word per cycle. Dump and remove on an
// empty store produce nothing. The output register lets the next input word be
// taken while a result waits.
module array_extract_minimum
    import aem_pkg::*;
#(
    parameter int DEPTH = AEM_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_cmd,
    input  logic                         i_start_new,
    input  logic signed [AEM_DATA_W-1:0] i_data_in,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [AEM_DATA_W-1:0] o_data_out,
    output logic                         o_kind,
    output logic                         o_last
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_DUMP_RD = 5'b00010,
        S_DUMP_WR = 5'b00100,
        S_SCAN    = 5'b01000,
        S_SHIFT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  append_base;

    // Scan and shift pipeline tracking.
    logic              r_rv;
    logic [ADDR_W-1:0] r_ridx;
    logic              r_wv;
    logic [ADDR_W-1:0] r_widx;
    logic signed [AEM_DATA_W-1:0] r_best;
    logic [ADDR_W-1:0] r_pos;

    // Pending result, waiting for the output register.
    logic                         r_pend;
    logic signed [AEM_DATA_W-1:0] r_pd_data;
    logic                         r_pd_kind;
    logic                         r_pd_last;
    logic                         pend_set;
    logic                         pend_drain;

    // Output register.
    logic                         r_out_valid;
    logic signed [AEM_DATA_W-1:0] r_out_data;
    logic                         r_out_kind;
    logic                         r_out_last;

    // RAM controls.
    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [AEM_DATA_W-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [AEM_DATA_W-1:0] ram_rd_data;

    logic accept;
    logic scan_done;
    logic shift_done;
    logic dump_last;

    assign o_ready     = (r_state == S_IDLE) && !r_pend;
    assign accept      = i_valid && o_ready;
    assign append_base = i_start_new ? '0 : r_count;
    assign scan_done   = (r_state == S_SCAN) && (r_idx == r_count) && !r_rv;
    assign shift_done  = (r_state == S_SHIFT) && (r_idx == r_count) && !r_wv;
    assign dump_last   = (r_idx == r_count - CNT_W'(1));
    assign pend_drain  = r_pend && (!r_out_valid || i_ready);
    assign pend_set    = (r_state == S_DUMP_WR) || scan_done;

    aem_ram #(
        .WIDTH (AEM_DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Next state, count and RAM access selection.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_widx - ADDR_W'(1);
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_idx[ADDR_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_APPEND: begin
                            n_count = append_base;
                            if (append_base != CNT_W'(DEPTH)) begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = append_base[ADDR_W-1:0];
                                ram_wr_data = i_data_in;
                                n_count     = append_base + CNT_W'(1);
                            end
                        end
                        CMD_DUMP: begin
                            if (r_count != '0) begin
                                n_state = S_DUMP_RD;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DUMP_RD: begin
                if (!r_pend) begin
                    ram_rd_en = 1'b1;
                    n_state   = S_DUMP_WR;
                end
            end
            S_DUMP_WR: begin
                n_state = dump_last ? S_IDLE : S_DUMP_RD;
            end
            S_SCAN: begin
                ram_rd_en = (r_idx != r_count);
                if (scan_done) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                ram_rd_en = (r_idx != r_count);
                ram_wr_en = r_wv;
                if (shift_done) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rv        <= 1'b0;
            r_wv        <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rv    <= (r_state == S_SCAN) && ram_rd_en;
            r_wv    <= (r_state == S_SHIFT) && ram_rd_en;
            if (pend_set) begin
                r_pend <= 1'b1;
            end else if (pend_drain) begin
                r_pend <= 1'b0;
            end
            if (!r_out_valid || i_ready) begin
                r_out_valid <= r_pend;
            end
        end
    end

    // Read index: walks the store for dump, scan and shift.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx <= '0;
        end else if ((r_state == S_DUMP_WR) && !dump_last) begin
            r_idx <= r_idx + CNT_W'(1);
        end else if (scan_done) begin
            r_idx <= CNT_W'(r_pos) + CNT_W'(1);
        end else if ((r_state == S_SCAN || r_state == S_SHIFT) && ram_rd_en) begin
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    // Minimum search: keep the first smallest word and its position.
    always_ff @(posedge i_clk) begin
        r_ridx <= r_idx[ADDR_W-1:0];
        r_widx <= r_idx[ADDR_W-1:0];
        if (r_rv) begin
            if ((r_ridx == '0) || ($signed(ram_rd_data) < r_best)) begin
                r_best <= $signed(ram_rd_data);
                r_pos  <= r_ridx;
            end
        end
    end

    // Pending result capture.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DUMP_WR) begin
            r_pd_data <= $signed(ram_rd_data);
            r_pd_kind <= KIND_DUMP;
            r_pd_last <= dump_last;
        end else if (scan_done) begin
            r_pd_data <= r_best;
            r_pd_kind <= KIND_MIN;
            r_pd_last <= 1'b1;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (pend_drain) begin
            r_out_data <= r_pd_data;
            r_out_kind <= r_pd_kind;
            r_out_last <= r_pd_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_data_out = r_out_data;
    assign o_kind     = r_out_kind;
    assign o_last     = r_out_last;

endmodule

FILE: hdl/aem_chk.sv
// Port-level checker for the minimum-extracting value store, bound to the top level.
module aem_chk
    import aem_pkg::*;
(
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic [1:0]                   i_cmd,
    input logic                         i_start_new,
    input logic signed [AEM_DATA_W-1:0] i_data_in,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic signed [AEM_DATA_W-1:0] o_data_out,
    input logic                         o_kind,
    input logic                         o_last
);

    // A stalled result word keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data_out) && $stable(o_kind)
            && $stable(o_last))
        else $error("result word changed while stalled");

    // A removed minimum is always the only, and so the last, result of its command.
    a_min_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_MIN) |-> o_last)
        else $error("removed minimum without last flag");

    // Reset leaves no result word behind.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid after reset");

    // Reset leaves the block ready for a new word.
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("block not ready after reset");

endmodule

bind array_extract_minimum aem_chk u_aem_chk (.*);

FILE: dv/tb.sv
// Self-checking testbench for the minimum-extracting value store.
module tb;
    import aem_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The block ignores this command code.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int NUM_DIRECTED = 25;
    localparam int RANDOM_WORDS = 95;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 300;

    // One result word as it leaves the block.
    typedef struct packed {
        logic [31:0] value;
        logic        kind;
        logic        last;
    } t_result;

    // One directed stimulus row; typed rows carry their own expected outcome.
    typedef struct packed {
        logic [1:0]  cmd;
        logic        start;
        logic [31:0] data;
        logic        typed;
        logic        has_result;
        logic [31:0] exp_data;
        logic        exp_kind;
    } t_stim_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [1:0]                   i_cmd;
    logic                         i_start_new;
    logic signed [AEM_DATA_W-1:0] i_data_in;
    logic                         o_valid;
    logic                         i_ready;
    logic signed [AEM_DATA_W-1:0] o_data_out;
    logic                         o_kind;
    logic                         o_last;

    // Predicted contents of the store, oldest entry first.
    logic signed [31:0] min_store[$];
    t_result            step_results[$];
    t_result            pending_outputs[$];
    int                 mismatches = 0;
    int                 words_sent = 0;
    int                 idle_cycles = 0;
    bit                 no_idle = 1'b0;

    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{CMD_DUMP,   1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0, KIND_DUMP},
        '{CMD_REMOVE, 1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0, KIND_MIN},
        '{CMD_UNUSED, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, KIND_DUMP},
        '{CMD_APPEND, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0, KIND_DUMP},
        '{CMD_APPEND, 1'b0, 32'h8000_0000, 1'b1, 1'b0, 32'h0, KIND_DUMP},
        '{CMD_APPEND, 1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0, KIND_DUMP},
        '{CMD_APPEND, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, KIND_DUMP},
        '{CMD_APPEND, 1'b0, 32'h0000_0001, 1'b1, 1'b0, 32'h0, KIND_DUMP},
        '{CMD_DUMP,   1'b0, 32'h1234_5678, 1'b0, 1'b0, 32'h0, KIND_DUMP},
        '{CMD_REMOVE, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000, KIND_MIN},
        '{CMD_APPEND, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, KIND_DUMP},
        '{CMD_REMOVE, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0, KIND_MIN},
        '{CMD_DUMP,   1'b1, 32'h0000_0000, 1'b0, 1'b0, 32'h0, KIND_DUMP},
        '{CMD_REMOVE, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0, KIND_MIN},
        '{CMD_APPEND, 1'b1, 32'h0000_0005, 1'b1, 1'b0, 32'h0, KIND_DUMP},
        '{CMD_DUMP,   1'b0, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0005, KIND_DUMP},
        '{CMD_REMOVE, 1'b0, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0005, KIND_MIN},
        '{CMD_REMOVE, 1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0, KIND_MIN},
        '{CMD_UNUSED, 1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0, KIND_DUMP},
        '{CMD_APPEND, 1'b0, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0, KIND_DUMP},
        '{CMD_APPEND, 1'b0, 32'h5555_5555, 1'b1, 1'b0, 32'h0, KIND_DUMP},
        '{CMD_REMOVE, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0, KIND_MIN},
        '{CMD_DUMP,   1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0, KIND_DUMP},
        '{CMD_APPEND, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0, KIND_DUMP},
        '{CMD_REMOVE, 1'b0, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, KIND_MIN}
    };

    array_extract_minimum i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_start_new (i_start_new),
        .i_data_in   (i_data_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data_out  (o_data_out),
        .o_kind      (o_kind),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Apply one accepted word to the predicted store and collect its results.
    function automatic void step_store(logic [1:0] cmd, logic start, logic [31:0] data);
        int                 pos;
        logic signed [31:0] best;
        t_result            r;
        step_results.delete();
        case (cmd)
            CMD_APPEND: begin
                if (start)
                    min_store.delete();
                // A full store drops the write.
                if (min_store.size() < AEM_DEPTH)
                    min_store.push_back(data);
            end
            CMD_DUMP: begin
                for (int i = 0; i < min_store.size(); i++) begin
                    r.value = min_store[i];
                    r.kind  = KIND_DUMP;
                    r.last  = (i == min_store.size() - 1);
                    step_results.push_back(r);
                end
            end
            CMD_REMOVE: begin
                if (min_store.size() != 0) begin
                    pos  = 0;
                    best = min_store[0];
                    // Strict compare keeps the earliest entry on ties.
                    for (int i = 1; i < min_store.size(); i++) begin
                        if (min_store[i] < best) begin
                            best = min_store[i];
                            pos  = i;
                        end
                    end
                    min_store.delete(pos);
                    r.value = best;
                    r.kind  = KIND_MIN;
                    r.last  = 1'b1;
                    step_results.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endfunction

    // Offer one input word after a random gap and wait until it is taken.
    task automatic send_word(input logic [1:0] cmd, input logic start, input logic [31:0] data,
                             input bit use_prediction);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_start_new <= start;
        i_data_in   <= data;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        step_store(cmd, start, data);
        if (use_prediction) begin
            foreach (step_results[k])
                pending_outputs.push_back(step_results[k]);
        end
        words_sent++;
    endtask

    // Hold off the sender until every predicted result has been taken.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_outputs.size() != 0);
    endtask

    // Mix of full-range values, small values that tie often, and the extremes.
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'($urandom_range(0, 6)) - 32'd3;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Sender: directed table, then random sequences.
    initial begin
        t_stim_row   row;
        t_result     r;
        logic [1:0]  op;
        int          n_words;
        bit          filled;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_cmd       <= CMD_APPEND;
        i_start_new <= 1'b0;
        i_data_in   <= '0;
        filled = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            send_word(row.cmd, row.start, row.data, !row.typed);
            if (row.typed && row.has_result) begin
                r.value = row.exp_data;
                r.kind  = row.exp_kind;
                r.last  = 1'b1;
                pending_outputs.push_back(r);
            end
        end

        while (words_sent < NUM_DIRECTED + RANDOM_WORDS) begin
            if (!filled && words_sent > NUM_DIRECTED + 10) begin
                // Fill the store past capacity, then read and drain part of it.
                filled = 1'b1;
                send_word(CMD_APPEND, 1'b1, pick_value(), 1'b1);
                repeat (AEM_DEPTH + 2)
                    send_word(CMD_APPEND, 1'b0, pick_value(), 1'b1);
                send_word(CMD_DUMP, 1'b0, $urandom, 1'b1);
                wait_for_results();
                send_word(CMD_REMOVE, 1'b0, $urandom, 1'b1);
                send_word(CMD_APPEND, 1'b0, pick_value(), 1'b1);
                send_word(CMD_APPEND, 1'b0, pick_value(), 1'b1);
                send_word(CMD_DUMP, 1'b0, $urandom, 1'b1);
                send_word(CMD_APPEND, 1'b1, pick_value(), 1'b1);
                send_word(CMD_DUMP, 1'b0, $urandom, 1'b1);
            end
            case ($urandom_range(0, 9))
                7: begin
                    // Noise: any command code, any flag.
                    repeat ($urandom_range(1, 4))
                        send_word(2'($urandom_range(0, 3)), 1'($urandom), $urandom, 1'b1);
                end
                8: begin
                    // Remove until the store is empty, plus one more.
                    n_words = min_store.size();
                    repeat (n_words + 1)
                        send_word(CMD_REMOVE, 1'($urandom), $urandom, 1'b1);
                end
                9: no_idle = !no_idle;
                default: begin
                    // Build a fresh list, then read it back and pull minima.
                    send_word(CMD_APPEND, 1'b1, pick_value(), 1'b1);
                    repeat ($urandom_range(1, 10))
                        send_word(CMD_APPEND, 1'b0, pick_value(), 1'b1);
                    repeat ($urandom_range(1, 4)) begin
                        op = ($urandom_range(0, 2) == 0) ? CMD_DUMP : CMD_REMOVE;
                        send_word(op, 1'($urandom), $urandom, 1'b1);
                    end
                end
            endcase
            if ($urandom_range(0, 3) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("array_extract_minimum test passed");
        end else begin
            $display("array_extract_minimum test failed");
        end
        $finish;
    end

    // Receiver: random stalls, and each taken word checked against the oldest prediction.
    initial begin
        int      stall;
        t_result want;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            if (pending_outputs.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result, expected none, actual %h kind %b last %b",
                         $time, o_data_out, o_kind, o_last);
            end else begin
                want = pending_outputs.pop_front();
                compare_field("data_out", want.value, o_data_out);
                compare_field("kind", 32'(want.kind), 32'(o_kind));
                compare_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    // Watchdog: too long without any word moving on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("array_extract_minimum test failed");
                $finish;
            end
        end
    end

endmodule

FILE: array_extract_minimum.f
hdl/aem_pkg.sv
hdl/aem_ram.sv
hdl/array_extract_minimum.sv
hdl/aem_chk.sv
dv/tb.sv
